// ===== design/isif_pkg.sv =====
// ----------------------------------------------------------------------------
// isif_pkg
// Shared types and codes for the insertion-sort inversion finder.
// ----------------------------------------------------------------------------
package isif_pkg;

   localparam int unsigned COORD_W   = 32;
   localparam int unsigned ID_W      = 5;
   localparam int unsigned RIDX_W    = 6;
   localparam int unsigned INV_CNT_W = 6;

   // Most inversions one insert may report (one slot stays for insert done)
   localparam logic [INV_CNT_W-1:0] INV_LIMIT = 6'd63;

   // Request codes
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_READ   = 1'b1;

   // Result kinds
   localparam logic [1:0] KIND_INV  = 2'd0;
   localparam logic [1:0] KIND_DONE = 2'd1;
   localparam logic [1:0] KIND_READ = 2'd2;
   localparam logic [1:0] KIND_OVER = 2'd3;

   typedef struct packed {
      logic                       req_type;
      logic signed [COORD_W-1:0]  coord;
      logic [ID_W-1:0]            particle_id;
      logic                       is_min;
      logic                       absent;
      logic                       first_of_frame;
      logic [RIDX_W-1:0]          read_index;
   } req_item_type;

   typedef struct packed {
      logic [1:0]                 kind;
      logic [ID_W-1:0]            first_id;
      logic [ID_W-1:0]            second_id;
      logic signed [COORD_W-1:0]  coord_out;
      logic                       is_min_out;
      logic                       absent_out;
      logic                       last;
   } rsp_item_type;

   // One stored bound
   typedef struct packed {
      logic signed [COORD_W-1:0]  coord;
      logic [ID_W-1:0]            particle_id;
      logic                       is_min;
      logic                       absent;
   } bound_type;

   // Controller to datapath
   typedef struct packed {
      logic load;       // capture the request item
      logic rd_req;     // read store at the requested index
      logic rd_prev;    // read store entry below the insert position
      logic shift;      // move read entry up one slot, step position down
      logic place;      // write new bound at position, count it, report done
      logic emit_read;  // report read data
      logic emit_over;  // report overflow
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_read;
      logic is_absent;
      logic full;
      logic pos_zero;
      logic pos_one;
      logic move;
   } status_type;

endpackage

// ===== design/isif_ctrl.sv =====
// ----------------------------------------------------------------------------
// isif_ctrl
// Sequencer for the inversion finder: dispatches reads and inserts and walks
// an insert down the store one entry per cycle.
// ----------------------------------------------------------------------------
module isif_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  isif_pkg::status_type status,
   output logic                 busy,
   output isif_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_DISPATCH = 3'd1;
   localparam logic [2:0] ST_READ     = 3'd2;
   localparam logic [2:0] ST_SHIFT    = 3'd3;
   localparam logic [2:0] ST_PLACE    = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign busy = (state_ff != ST_IDLE);

   // Decode commands and next state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (status.is_read) begin
               cmd.rd_req = 1'b1;
               state_in   = ST_READ;
            end else if (status.full) begin
               cmd.emit_over = 1'b1;
               state_in      = ST_IDLE;
            end else if (status.is_absent || status.pos_zero) begin
               cmd.place = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               cmd.rd_prev = 1'b1;
               state_in    = ST_SHIFT;
            end
         end
         ST_READ: begin
            cmd.emit_read = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_SHIFT: begin
            if (status.move) begin
               cmd.shift = 1'b1;
               state_in  = status.pos_one ? ST_PLACE : ST_SHIFT;
            end else begin
               cmd.place = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_PLACE: begin
            cmd.place = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/isif_datapath.sv =====
// ----------------------------------------------------------------------------
// isif_datapath
// Bound store, fill count, insert position and result register of the
// inversion finder.
// ----------------------------------------------------------------------------
module isif_datapath #(
   parameter int unsigned MAX_BOUNDS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  isif_pkg::req_item_type req_item,
   input  isif_pkg::cmd_type      cmd,
   output isif_pkg::status_type   status,
   output logic                   rsp_strobe,
   output isif_pkg::rsp_item_type rsp_item
);

   localparam int unsigned IDX_W = $clog2(MAX_BOUNDS);
   localparam int unsigned CNT_W = $clog2(MAX_BOUNDS + 1);
   localparam logic [CNT_W-1:0] DEPTH = CNT_W'(MAX_BOUNDS);

   isif_pkg::req_item_type              req_ff;
   isif_pkg::bound_type                 mem [MAX_BOUNDS];
   isif_pkg::bound_type                 rd_data_ff;
   isif_pkg::bound_type                 new_bound;
   isif_pkg::bound_type                 wr_data;
   logic [CNT_W-1:0]                    count_ff;
   logic [CNT_W-1:0]                    pos_ff;
   logic [CNT_W-1:0]                    pos_m1;
   logic [CNT_W-1:0]                    pos_m2;
   logic [isif_pkg::INV_CNT_W-1:0]      inv_cnt_ff;
   logic                                rsp_strobe_ff;
   logic                                rsp_strobe_in;
   isif_pkg::rsp_item_type              rsp_ff;
   isif_pkg::rsp_item_type              rsp_in;
   logic                                rd_en;
   logic [IDX_W-1:0]                    rd_addr;
   logic                                wr_en;
   logic [IDX_W-1:0]                    wr_addr;
   logic                                inv_hit;
   logic                                rd_ok;
   logic                                clear_frame;
   logic [isif_pkg::ID_W-1:0]           id_lo;
   logic [isif_pkg::ID_W-1:0]           id_hi;

   assign new_bound.coord       = req_ff.coord;
   assign new_bound.particle_id = req_ff.particle_id;
   assign new_bound.is_min      = req_ff.is_min;
   assign new_bound.absent      = req_ff.absent;

   assign pos_m1 = pos_ff - CNT_W'(1);
   assign pos_m2 = pos_ff - CNT_W'(2);

   assign clear_frame = (req_item.req_type == isif_pkg::REQ_INSERT) &&
                        req_item.first_of_frame;

   // Status toward the controller
   always_comb begin
      status.is_read   = (req_ff.req_type == isif_pkg::REQ_READ);
      status.is_absent = req_ff.absent;
      status.full      = (count_ff == DEPTH);
      status.pos_zero  = (pos_ff == '0);
      status.pos_one   = (pos_ff == CNT_W'(1));
      status.move      = rd_data_ff.absent || (rd_data_ff.coord > req_ff.coord);
   end

   // Store port control
   always_comb begin
      rd_en   = cmd.rd_req || cmd.rd_prev || cmd.shift;
      rd_addr = pos_m1[IDX_W-1:0];
      if (cmd.rd_req) begin
         rd_addr = IDX_W'(req_ff.read_index);
      end else if (cmd.shift) begin
         rd_addr = pos_m2[IDX_W-1:0];
      end
      wr_en   = cmd.shift || cmd.place;
      wr_addr = pos_ff[IDX_W-1:0];
      wr_data = cmd.shift ? rd_data_ff : new_bound;
   end

   // Bound store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Build the next result
   always_comb begin
      inv_hit = !rd_data_ff.absent && (rd_data_ff.is_min != req_ff.is_min) &&
                (inv_cnt_ff != isif_pkg::INV_LIMIT);
      rd_ok   = (32'(req_ff.read_index) < 32'(count_ff));
      id_lo   = (req_ff.particle_id < rd_data_ff.particle_id) ?
                req_ff.particle_id : rd_data_ff.particle_id;
      id_hi   = (req_ff.particle_id < rd_data_ff.particle_id) ?
                rd_data_ff.particle_id : req_ff.particle_id;
      rsp_in        = '0;
      rsp_strobe_in = 1'b0;
      if (cmd.shift && inv_hit) begin
         rsp_strobe_in    = 1'b1;
         rsp_in.kind      = isif_pkg::KIND_INV;
         rsp_in.first_id  = req_ff.is_min ? id_lo : id_hi;
         rsp_in.second_id = req_ff.is_min ? id_hi : id_lo;
      end else if (cmd.place) begin
         rsp_strobe_in = 1'b1;
         rsp_in.kind   = isif_pkg::KIND_DONE;
         rsp_in.last   = 1'b1;
      end else if (cmd.emit_over) begin
         rsp_strobe_in = 1'b1;
         rsp_in.kind   = isif_pkg::KIND_OVER;
         rsp_in.last   = 1'b1;
      end else if (cmd.emit_read) begin
         rsp_strobe_in = 1'b1;
         rsp_in.kind   = isif_pkg::KIND_READ;
         rsp_in.last   = 1'b1;
         if (rd_ok) begin
            rsp_in.first_id   = rd_data_ff.particle_id;
            rsp_in.coord_out  = rd_data_ff.coord;
            rsp_in.is_min_out = rd_data_ff.is_min;
            rsp_in.absent_out = rd_data_ff.absent;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         pos_ff        <= '0;
         inv_cnt_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
         if (cmd.load && clear_frame) begin
            count_ff <= '0;
         end else if (cmd.place) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.load) begin
            pos_ff <= clear_frame ? '0 : count_ff;
         end else if (cmd.shift) begin
            pos_ff <= pos_m1;
         end
         if (cmd.load) begin
            inv_cnt_ff <= '0;
         end else if (cmd.shift && inv_hit) begin
            inv_cnt_ff <= inv_cnt_ff + isif_pkg::INV_CNT_W'(1);
         end
      end
   end

   // Hold request and result payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_item;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

`ifndef SYNTHESIS
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH)
      else $error("fill count beyond store depth");

   a_place_counts: assert property (@(posedge clock) disable iff (reset)
      cmd.place |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("placed bound not counted");

   a_shift_steps: assert property (@(posedge clock) disable iff (reset)
      cmd.shift |=> pos_ff == $past(pos_ff) - CNT_W'(1))
      else $error("insert position did not step down");

   a_shift_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.shift |-> pos_ff != '0)
      else $error("shift below the bottom of the store");

   a_place_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.place |-> count_ff != DEPTH)
      else $error("insert into a full store");
`endif

endmodule

// ===== design/insertion_sort_inversion_finder.sv =====
// ----------------------------------------------------------------------------
// insertion_sort_inversion_finder
// Sweep-and-prune axis sorter: insertion-sorts box bounds into a store and
// reports the min/max crossings each insert makes.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_item and raise start; the item is taken at an edge where start
//   is high and busy is low. An insert answers with its inversion pairs, at most
//   one per cycle, then one insert-done result with last set; a full store gives
//   one overflow result instead. A read answers one read-data result.
//   Each result shows on rsp_item for one cycle with rsp_strobe high; the
//   receiver cannot stall, so every result must be taken when it shows.
// Sequencing:
//   A read passes through the dispatch and read states with busy high; its
//   result is registered out of the read state. An insert passes dispatch,
//   the shift state once per stored entry it passes, then a place step; an
//   absent insert, one into an empty store and an overflow end in dispatch.
//   The walk uses the single write and single read port, one entry per cycle.
//   Results trail the cycle that makes them by one register.
//   A new item may be taken while the last result is still on the port.
// Reset:
//   Synchronous reset empties the store (fill count zero) and drops any
//   item in flight; store contents are not cleared.
// ----------------------------------------------------------------------------
module insertion_sort_inversion_finder #(
   parameter int unsigned MAX_BOUNDS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  isif_pkg::req_item_type req_item,
   output logic                   rsp_strobe,
   output isif_pkg::rsp_item_type rsp_item
);

   isif_pkg::cmd_type    cmd;
   isif_pkg::status_type status;

   isif_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   isif_datapath #(
      .MAX_BOUNDS (MAX_BOUNDS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

// ===== tb/tb_insertion_sort_inversion_finder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_insertion_sort_inversion_finder
// Self-checking bench for the sweep-and-prune insertion sorter. A directed
// table covers extremes, equal coordinates, absent bounds, reads with and
// past the fill count, then random frames follow: one full frame that ends in
// overflow and a maximal inversion burst, then short frames with random gaps.
// A shadow copy of the sorted store predicts the results; some table rows give their single result kind directly.
// ----------------------------------------------------------------------------
module tb_insertion_sort_inversion_finder;

   localparam int unsigned MAX_BOUNDS   = 64;
   localparam int          RANDOM_ITEMS = 91;
   localparam int          CYCLE_LIMIT  = 200000;
   localparam int          REPORT_MAX   = 10;

   typedef struct {
      isif_pkg::req_item_type item;
      bit                     typed;
      logic [1:0]             kind;
   } stim_row_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   isif_pkg::req_item_type req_item;
   logic                   rsp_strobe;
   isif_pkg::rsp_item_type rsp_item;

   // Shadow of the sorted store
   isif_pkg::bound_type    shadow_bounds [MAX_BOUNDS];
   int                     shadow_count;
   int                     peak_count;

   isif_pkg::rsp_item_type rsp_due [$];
   stim_row_type           directed_rows [$];
   int                     error_count;
   int                     cycle_count;

   insertion_sort_inversion_finder #(
      .MAX_BOUNDS(MAX_BOUNDS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always #2 clock = ~clock;

   // Single result with only kind and last set
   function automatic isif_pkg::rsp_item_type lone_rsp(input logic [1:0] k);
      isif_pkg::rsp_item_type r;
      r      = '0;
      r.kind = k;
      r.last = 1'b1;
      return r;
   endfunction

   // Apply one item to the shadow store and list the results it causes
   function automatic void sort_bound(input isif_pkg::req_item_type it,
                                      output isif_pkg::rsp_item_type res[$]);
      isif_pkg::rsp_item_type    r;
      isif_pkg::bound_type       nb;
      isif_pkg::bound_type       e;
      int                        pos;
      int                        n_inv;
      logic [isif_pkg::ID_W-1:0] lo, hi;
      res = {};
      r   = '0;
      if (it.req_type == isif_pkg::REQ_READ) begin
         r.kind = isif_pkg::KIND_READ;
         r.last = 1'b1;
         if (int'(it.read_index) < shadow_count) begin
            e            = shadow_bounds[it.read_index];
            r.first_id   = e.particle_id;
            r.coord_out  = e.coord;
            r.is_min_out = e.is_min;
            r.absent_out = e.absent;
         end
         res = {res, r};
         return;
      end
      if (it.first_of_frame)
         shadow_count = 0;
      if (shadow_count >= int'(MAX_BOUNDS)) begin
         res = {res, lone_rsp(isif_pkg::KIND_OVER)};
         return;
      end
      nb.coord       = it.coord;
      nb.particle_id = it.particle_id;
      nb.is_min      = it.is_min;
      nb.absent      = it.absent;
      pos   = shadow_count;
      n_inv = 0;
      // Walk down past greater or absent entries, reporting kind crossings
      if (!it.absent) begin
         while (pos > 0 && (shadow_bounds[pos-1].absent ||
                $signed(shadow_bounds[pos-1].coord) > $signed(it.coord))) begin
            e = shadow_bounds[pos-1];
            if (!e.absent && e.is_min != it.is_min &&
                n_inv < int'(isif_pkg::INV_LIMIT)) begin
               lo = (it.particle_id < e.particle_id) ? it.particle_id : e.particle_id;
               hi = (it.particle_id < e.particle_id) ? e.particle_id : it.particle_id;
               r  = '0;
               r.kind      = isif_pkg::KIND_INV;
               r.first_id  = it.is_min ? lo : hi;
               r.second_id = it.is_min ? hi : lo;
               res = {res, r};
               n_inv++;
            end
            shadow_bounds[pos] = e;
            pos--;
         end
      end
      shadow_bounds[pos] = nb;
      shadow_count++;
      if (shadow_count > peak_count)
         peak_count = shadow_count;
      res = {res, lone_rsp(isif_pkg::KIND_DONE)};
   endfunction

   // Hold start until the block takes the item, then queue its results
   task automatic send_item(input isif_pkg::req_item_type it, input bit typed,
                            input logic [1:0] typed_kind, input int gap);
      isif_pkg::rsp_item_type due [$];
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
      sort_bound(it, due);
      if (typed)
         rsp_due = {rsp_due, lone_rsp(typed_kind)};
      else
         foreach (due[i]) rsp_due = {rsp_due, due[i]};
   endtask

   task automatic add_row(input logic rt, input logic [31:0] crd, input int id,
                          input logic mn, input logic ab, input logic fof,
                          input int ridx, input bit typed, input logic [1:0] k);
      stim_row_type row;
      row.item.req_type       = rt;
      row.item.coord          = crd;
      row.item.particle_id    = id[isif_pkg::ID_W-1:0];
      row.item.is_min         = mn;
      row.item.absent         = ab;
      row.item.first_of_frame = fof;
      row.item.read_index     = ridx[isif_pkg::RIDX_W-1:0];
      row.typed               = typed;
      row.kind                = k;
      directed_rows = {directed_rows, row};
   endtask

   function automatic isif_pkg::req_item_type rand_insert(input bit fof, input bit narrow);
      isif_pkg::req_item_type it;
      it.req_type       = isif_pkg::REQ_INSERT;
      it.coord          = narrow ? ((32'($urandom_range(0, 12)) - 32'd6) << 16)
                                 : $urandom();
      it.particle_id    = isif_pkg::ID_W'($urandom_range(0, 31));
      it.is_min         = 1'($urandom_range(0, 1));
      it.absent         = ($urandom_range(0, 7) == 0);
      it.first_of_frame = fof;
      it.read_index     = isif_pkg::RIDX_W'($urandom_range(0, 63));
      return it;
   endfunction

   // Read with junk in the ignored fields; only indexes already written
   function automatic isif_pkg::req_item_type rand_read();
      isif_pkg::req_item_type it;
      int                     idx;
      if (shadow_count > 0 &&
          ($urandom_range(0, 3) != 0 || peak_count <= shadow_count))
         idx = int'($urandom_range(0, shadow_count - 1));
      else
         idx = int'($urandom_range(shadow_count, peak_count - 1));
      it                = '0;
      it.req_type       = isif_pkg::REQ_READ;
      it.coord          = $urandom();
      it.particle_id    = isif_pkg::ID_W'($urandom_range(0, 31));
      it.is_min         = 1'($urandom_range(0, 1));
      it.absent         = 1'($urandom_range(0, 1));
      it.first_of_frame = 1'($urandom_range(0, 1));
      it.read_index     = isif_pkg::RIDX_W'(idx);
      return it;
   endfunction

   function automatic int draw_gap(input bit burst);
      return burst ? 0 : int'($urandom_range(0, 13));
   endfunction

   // Check each result against the oldest expectation
   always @(posedge clock) begin
      isif_pkg::rsp_item_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, rsp_due.size());
         $display("Verification failed");
         $finish;
      end
      if (!reset && rsp_strobe === 1'b1) begin
         if (rsp_due.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_MAX)
               $display("%0t: unexpected result kind=%0d first=%0d second=%0d last=%0d",
                        $realtime, rsp_item.kind, rsp_item.first_id,
                        rsp_item.second_id, rsp_item.last);
         end else begin
            want = rsp_due.pop_front();
            if (rsp_item.kind !== want.kind || rsp_item.first_id !== want.first_id ||
                rsp_item.second_id !== want.second_id ||
                rsp_item.coord_out !== want.coord_out ||
                rsp_item.is_min_out !== want.is_min_out ||
                rsp_item.absent_out !== want.absent_out ||
                rsp_item.last !== want.last) begin
               error_count++;
               if (error_count <= REPORT_MAX) begin
                  $display("%0t: mismatch exp kind=%0d first=%0d second=%0d",
                           $realtime, want.kind, want.first_id, want.second_id);
                  $display("      exp coord=%h min=%b abs=%b last=%b",
                           want.coord_out, want.is_min_out, want.absent_out,
                           want.last);
                  $display("      got kind=%0d first=%0d second=%0d",
                           rsp_item.kind, rsp_item.first_id, rsp_item.second_id);
                  $display("      got coord=%h min=%b abs=%b last=%b",
                           rsp_item.coord_out, rsp_item.is_min_out,
                           rsp_item.absent_out, rsp_item.last);
               end
            end
         end
      end
   end

   initial begin
      int                     items_left;
      int                     frame_len;
      int                     n_reads;
      bit                     burst;
      bit                     narrow;
      bit                     full_pending;
      logic [31:0]            ramp;
      isif_pkg::req_item_type it;

      clock        = 1'b0;
      reset        = 1'b1;
      start        = 1'b0;
      req_item     = '0;
      error_count  = 0;
      cycle_count  = 0;
      shadow_count = 0;
      peak_count   = 0;
      for (int i = 0; i < int'(MAX_BOUNDS); i++) shadow_bounds[i] = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed table: extremes, equal stop, absent, reads, read past end
      add_row(isif_pkg::REQ_INSERT, 32'h7FFF_FFFF, 31, 1'b0, 1'b0, 1'b1, 0,
              1'b1, isif_pkg::KIND_DONE);
      add_row(isif_pkg::REQ_INSERT, 32'h8000_0000, 0,  1'b1, 1'b0, 1'b0, 0,
              1'b0, isif_pkg::KIND_INV);
      add_row(isif_pkg::REQ_INSERT, 32'h0000_0000, 5,  1'b0, 1'b0, 1'b0, 0,
              1'b0, isif_pkg::KIND_INV);
      add_row(isif_pkg::REQ_INSERT, 32'h0000_0000, 6,  1'b1, 1'b0, 1'b0, 0,
              1'b0, isif_pkg::KIND_INV);
      add_row(isif_pkg::REQ_INSERT, 32'hDEAD_BEEF, 7,  1'b1, 1'b1, 1'b0, 0,
              1'b1, isif_pkg::KIND_DONE);
      add_row(isif_pkg::REQ_INSERT, 32'hFFFF_0000, 8,  1'b0, 1'b0, 1'b0, 0,
              1'b0, isif_pkg::KIND_INV);
      add_row(isif_pkg::REQ_INSERT, 32'h0001_0000, 3,  1'b1, 1'b0, 1'b0, 63,
              1'b0, isif_pkg::KIND_INV);
      add_row(isif_pkg::REQ_READ,   32'h0000_0000, 0,  1'b0, 1'b0, 1'b0, 0,
              1'b0, isif_pkg::KIND_READ);
      add_row(isif_pkg::REQ_READ,   32'hFFFF_FFFF, 31, 1'b1, 1'b1, 1'b1, 2,
              1'b0, isif_pkg::KIND_READ);
      add_row(isif_pkg::REQ_READ,   32'h0000_0000, 0,  1'b0, 1'b0, 1'b0, 6,
              1'b0, isif_pkg::KIND_READ);
      add_row(isif_pkg::REQ_READ,   32'h0000_0000, 0,  1'b0, 1'b0, 1'b0, 5,
              1'b0, isif_pkg::KIND_READ);
      add_row(isif_pkg::REQ_INSERT, 32'h0001_2345, 2,  1'b1, 1'b0, 1'b1, 0,
              1'b1, isif_pkg::KIND_DONE);
      add_row(isif_pkg::REQ_READ,   32'h0000_0000, 0,  1'b0, 1'b0, 1'b0, 6,
              1'b1, isif_pkg::KIND_READ);
      add_row(isif_pkg::REQ_READ,   32'h0000_0000, 0,  1'b0, 1'b0, 1'b1, 1,
              1'b1, isif_pkg::KIND_READ);
      add_row(isif_pkg::REQ_INSERT, 32'h0000_8000, 31, 1'b0, 1'b0, 1'b0, 0,
              1'b0, isif_pkg::KIND_INV);
      add_row(isif_pkg::REQ_INSERT, 32'h0000_8000, 2,  1'b0, 1'b0, 1'b0, 0,
              1'b0, isif_pkg::KIND_INV);
      add_row(isif_pkg::REQ_INSERT, 32'h0000_8000, 9,  1'b1, 1'b1, 1'b0, 0,
              1'b1, isif_pkg::KIND_DONE);
      add_row(isif_pkg::REQ_INSERT, 32'hFFFF_FFFF, 0,  1'b1, 1'b0, 1'b0, 0,
              1'b0, isif_pkg::KIND_INV);
      add_row(isif_pkg::REQ_READ,   32'h0000_0000, 0,  1'b0, 1'b0, 1'b0, 0,
              1'b0, isif_pkg::KIND_READ);

      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].typed,
                   directed_rows[i].kind, draw_gap($urandom_range(0, 2) == 0));

      // Random frames; the first one fills the store and runs into overflow
      items_left   = RANDOM_ITEMS;
      full_pending = 1'b1;
      while (items_left > 0) begin
         burst  = ($urandom_range(0, 2) == 0);
         narrow = ($urandom_range(0, 2) != 0);
         if (full_pending) begin
            full_pending = 1'b0;
            // Rising upper bounds, then one lower bound that crosses them all
            ramp = 32'hFFF0_0000 - 32'($urandom_range(0, 32'hFFFF));
            for (int k = 0; k < int'(MAX_BOUNDS) - 1; k++) begin
               it          = rand_insert(k == 0, 1'b0);
               it.is_min   = 1'b0;
               it.absent   = 1'b0;
               it.coord    = ramp;
               ramp        = ramp + 32'($urandom_range(1, 32'h3_0000));
               send_item(it, 1'b0, isif_pkg::KIND_INV, draw_gap(burst));
               items_left--;
            end
            it        = rand_insert(1'b0, 1'b0);
            it.is_min = 1'b1;
            it.absent = 1'b0;
            it.coord  = 32'h8000_0000;
            send_item(it, 1'b0, isif_pkg::KIND_INV, draw_gap(burst));
            // Store is full: inserts overflow, reads reach the top entry
            send_item(rand_insert(1'b0, 1'b0), 1'b1, isif_pkg::KIND_OVER,
                      draw_gap(burst));
            send_item(rand_insert(1'b0, 1'b1), 1'b1, isif_pkg::KIND_OVER,
                      draw_gap(burst));
            it            = rand_read();
            it.read_index = isif_pkg::RIDX_W'(MAX_BOUNDS - 1);
            send_item(it, 1'b0, isif_pkg::KIND_READ, draw_gap(burst));
            send_item(rand_read(), 1'b0, isif_pkg::KIND_READ, draw_gap(burst));
            items_left = items_left - 5;
         end else begin
            frame_len = int'($urandom_range(1, 14));
            n_reads   = 0;
            for (int k = 0; k < frame_len && items_left > 0; k++) begin
               if (k > 0 && $urandom_range(0, 4) == 0) begin
                  send_item(rand_read(), 1'b0, isif_pkg::KIND_READ, draw_gap(burst));
                  n_reads++;
               end else begin
                  // Mostly open a new frame; sometimes keep filling the old one
                  send_item(rand_insert((k == 0) && ($urandom_range(0, 7) != 0), narrow),
                            1'b0, isif_pkg::KIND_INV, draw_gap(burst));
               end
               items_left--;
            end
         end
      end

      // Drain outstanding results
      start <= 1'b0;
      while (rsp_due.size() != 0) @(posedge clock);
      repeat (MAX_BOUNDS + 8) @(posedge clock);

      if (rsp_due.size() != 0) begin
         error_count++;
         $display("%0d expected results never arrived", rsp_due.size());
      end
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
design/isif_pkg.sv
design/isif_ctrl.sv
design/isif_datapath.sv
design/insertion_sort_inversion_finder.sv
tb/tb_insertion_sort_inversion_finder.sv
